@@ hdl/assert_macros.svh @@
// Assertion helpers; the enclosing module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/pps_pkg.sv @@
`default_nettype none
package pps_pkg;

    localparam int BUF_LEN_DEF = 256;

    localparam int MODE_W    = 3;
    localparam int ADC_W     = 16;
    localparam int PFX_W     = 15;
    localparam int ADDR_W    = 8;
    localparam int CNT_W     = 8;
    localparam int SPS_W     = 8;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_SCHED  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HALF1  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF2  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPS         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_ON = 2'd3;

    localparam logic [CNT_W-1:0] PULSE_COUNT_RST = 8'd4;
    localparam logic [SPS_W-1:0] SPS_RST         = 8'd6;
    localparam logic [1:0]       CLR_DELAY_MAX   = 2'd2;

    typedef enum logic {
        DIV_ADC,
        DIV_PFX
    } t_div_src;

    typedef struct packed {
        logic     latch_in;
        logic     div_start;
        t_div_src div_sel;
        logic     sched_commit;
        logic     half1;
        logic     half2;
        logic     upd_periodic;
        logic     period_apply;
        logic     train_erase;
        logic     train_fill;
        logic     train_step;
        logic     clr_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic              clr_last;
        logic              div_busy;
        logic              erase_go;
        logic              fill_go;
        logic              train_done;
        logic [MODE_W-1:0] mode;
    } t_stat;

endpackage
`default_nettype wire

@@ hdl/pps_if.sv @@
`default_nettype none
interface pps_in_if;
    logic                        valid;
    logic                        ready;
    logic [pps_pkg::MODE_W-1:0]  mode;
    logic [pps_pkg::ADC_W-1:0]   adc_index;
    logic [pps_pkg::PFX_W-1:0]   target_prefix;
    logic [pps_pkg::ADDR_W-1:0]  slot_address;

    modport source (output valid, mode, adc_index, target_prefix, slot_address,
                    input ready);
    modport sink   (input valid, mode, adc_index, target_prefix, slot_address,
                    output ready);
endinterface

interface pps_out_if;
    logic                        valid;
    logic                        ready;
    logic                        pin_level;
    logic [pps_pkg::PFX_W-1:0]   current_prefix;
    logic                        ping_pending;

    modport source (output valid, pin_level, current_prefix, ping_pending,
                    input ready);
    modport sink   (input valid, pin_level, current_prefix, ping_pending,
                    output ready);
endinterface
`default_nettype wire

@@ hdl/ping_pulse_scheduler_top.sv @@
// Ping pulse scheduler: one item in, one result beat out, one item at a time. After reset
// the waveform store is cleared one slot per cycle, so no item is taken until every slot
// is cleared (configuration writes are taken at any time). BUF_LEN must be a power of
// two: slot positions and read addresses wrap by masking. The time to a valid result is
// set by the 16-step serial divider and the single write port of the store: schedule
// runs one divider pass by samples_per_slot, first-half-done one pass for the period
// check, read, second-half-done and unknown modes need neither, and update erases the old
// train, then writes the new one, each only when due, one slot per cycle. The next item can
// be taken in the cycle after its result is loaded. A result waits in an output register
// until taken; while it waits, the following result holds the block and stalls the input.
`default_nettype none
module ping_pulse_scheduler_top #(
    parameter int BUF_LEN = pps_pkg::BUF_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pps_pkg::CFG_W-1:0]     i_cfg_data,
    pps_in_if.sink                             i_in,
    pps_out_if.source                          o_out
);
    import pps_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pps_dp #(
        .BUF_LEN (BUF_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_in.mode),
        .i_adc_index      (i_in.adc_index),
        .i_target_prefix  (i_in.target_prefix),
        .i_slot_address   (i_in.slot_address),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_pin_level      (o_out.pin_level),
        .o_current_prefix (o_out.current_prefix),
        .o_ping_pending   (o_out.ping_pending)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule
`default_nettype wire

@@ hdl/pps_dp.sv @@
`default_nettype none
module pps_dp #(
    parameter int BUF_LEN = pps_pkg::BUF_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pps_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [pps_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [pps_pkg::ADC_W-1:0]     i_adc_index,
    input  wire logic [pps_pkg::PFX_W-1:0]     i_target_prefix,
    input  wire logic [pps_pkg::ADDR_W-1:0]    i_slot_address,
    input  wire pps_pkg::t_cmd                 i_cmd,
    output pps_pkg::t_stat                     o_stat,
    output logic                               o_pin_level,
    output logic [pps_pkg::PFX_W-1:0]          o_current_prefix,
    output logic                               o_ping_pending
);
    import pps_pkg::*;

    localparam int IW  = $clog2(BUF_LEN);
    localparam int PW  = IW + 1;
    localparam int DW  = (PFX_W > SPS_W) ? PFX_W : SPS_W;
    localparam int DCW = $clog2(ADC_W + 1);

    logic [CNT_W-1:0]  r_pulse_count;
    logic [SPS_W-1:0]  r_sps;
    logic [PFX_W-1:0]  r_period;
    logic              r_periodic_on;

    logic              r_free_half;
    logic [PFX_W-1:0]  r_prefix;
    logic [1:0]        r_clear_delay;
    logic              r_period_due;
    logic              r_pend_valid;
    logic [ADC_W-1:0]  r_pend_slot;
    logic [IW-1:0]     r_pend_pos;
    logic [PFX_W-1:0]  r_pend_prefix;
    logic              r_erase_valid;
    logic [IW-1:0]     r_erase_pos;
    logic [IW-1:0]     r_clr_ptr;

    logic [MODE_W-1:0] r_mode;
    logic [ADC_W-1:0]  r_adc;
    logic [PFX_W-1:0]  r_pfx;
    logic [ADDR_W-1:0] r_addr;

    logic [DCW-1:0]    r_dv_cnt;
    logic [ADC_W-1:0]  r_dv_quo;
    logic [DW-1:0]     r_dv_rem;
    logic [DW-1:0]     r_dv_den;
    logic [DW:0]       dv_trial;
    logic [DW:0]       dv_diff;
    logic              dv_ge;
    logic [ADC_W-1:0]  dv_num_sel;
    logic [DW-1:0]     dv_den_sel;

    logic [IW-1:0]     r_tr_ptr;
    logic [CNT_W-1:0]  r_tr_k;
    logic              r_tr_lvl;
    logic [PW-1:0]     tr_sum;
    logic [IW-1:0]     tr_next;

    logic              r_wave [BUF_LEN];
    logic              r_rd;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic              mem_wdata;

    logic              low_half;
    logic              fits;

    logic              r_out_level;
    logic [PFX_W-1:0]  r_out_prefix;
    logic              r_out_pend;

    // configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count <= PULSE_COUNT_RST;
            r_sps         <= SPS_RST;
            r_period      <= '0;
            r_periodic_on <= 1'b0;
            r_free_half   <= 1'b1;
            r_prefix      <= '0;
            r_clear_delay <= CLR_DELAY_MAX;
            r_period_due  <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_pend_slot   <= '0;
            r_pend_pos    <= '0;
            r_pend_prefix <= '0;
            r_erase_valid <= 1'b0;
            r_erase_pos   <= '0;
            r_clr_ptr     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PULSE_COUNT: r_pulse_count <= i_cfg_data[CNT_W-1:0];
                    CFG_SPS:         r_sps         <= i_cfg_data[SPS_W-1:0];
                    CFG_PERIOD:      r_period      <= i_cfg_data[PFX_W-1:0];
                    CFG_PERIODIC_ON: r_periodic_on <= i_cfg_data[0];
                    default:         ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_ptr <= r_clr_ptr + 1'b1;
            end
            if (i_cmd.half1) begin
                r_prefix    <= r_prefix + 1'b1;
                r_free_half <= 1'b0;
                if (r_clear_delay < CLR_DELAY_MAX) begin
                    r_clear_delay <= r_clear_delay + 1'b1;
                end
            end
            if (i_cmd.half2) begin
                r_free_half <= 1'b1;
                if (r_clear_delay < CLR_DELAY_MAX) begin
                    r_clear_delay <= r_clear_delay + 1'b1;
                end
            end
            if (i_cmd.period_apply && (r_period != '0) && (r_dv_rem == '0)) begin
                r_period_due <= 1'b1;
            end
            if (i_cmd.sched_commit) begin
                r_pend_slot   <= r_dv_quo;
                r_pend_pos    <= r_dv_quo[IW-1:0];
                r_pend_prefix <= r_pfx;
                r_pend_valid  <= 1'b1;
            end
            if (i_cmd.upd_periodic && r_periodic_on && r_period_due) begin
                r_pend_slot   <= '0;
                r_pend_pos    <= '0;
                r_pend_prefix <= r_prefix;
                r_pend_valid  <= 1'b1;
                r_period_due  <= 1'b0;
            end
            if (i_cmd.train_erase) begin
                r_erase_valid <= 1'b0;
            end
            if (i_cmd.train_fill) begin
                r_erase_pos   <= r_pend_pos;
                r_erase_valid <= 1'b1;
                r_clear_delay <= '0;
                r_pend_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode <= i_mode;
            r_adc  <= i_adc_index;
            r_pfx  <= i_target_prefix;
            r_addr <= i_slot_address;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        dv_trial = {r_dv_rem, r_dv_quo[ADC_W-1]};
        dv_diff  = dv_trial - {1'b0, r_dv_den};
        dv_ge    = dv_trial >= {1'b0, r_dv_den};
        case (i_cmd.div_sel)
            DIV_ADC: begin
                dv_num_sel = r_adc;
                dv_den_sel = (r_sps == '0) ? DW'(1) : DW'(r_sps);
            end
            DIV_PFX: begin
                dv_num_sel = ADC_W'(r_prefix);
                dv_den_sel = DW'(r_period);
            end
            default: begin
                dv_num_sel = r_adc;
                dv_den_sel = DW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dv_cnt <= DCW'(ADC_W);
        end else if (r_dv_cnt != '0) begin
            r_dv_cnt <= r_dv_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_quo <= dv_num_sel;
            r_dv_rem <= '0;
            r_dv_den <= dv_den_sel;
        end else if (r_dv_cnt != '0) begin
            r_dv_rem <= dv_ge ? dv_diff[DW-1:0] : dv_trial[DW-1:0];
            r_dv_quo <= {r_dv_quo[ADC_W-2:0], dv_ge};
        end
    end

    // pulse train walker, alternate slots with wrap
    always_comb begin
        tr_sum  = {1'b0, r_tr_ptr} + PW'(2);
        tr_next = (tr_sum >= PW'(BUF_LEN)) ? IW'(tr_sum - PW'(BUF_LEN)) : tr_sum[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.train_erase) begin
            r_tr_ptr <= r_erase_pos;
            r_tr_k   <= '0;
            r_tr_lvl <= 1'b0;
        end else if (i_cmd.train_fill) begin
            r_tr_ptr <= r_pend_pos;
            r_tr_k   <= '0;
            r_tr_lvl <= 1'b1;
        end else if (i_cmd.train_step) begin
            r_tr_ptr <= tr_next;
            r_tr_k   <= r_tr_k + 1'b1;
        end
    end

    // waveform store
    always_comb begin
        mem_we    = i_cmd.clr_step | i_cmd.train_step;
        mem_waddr = i_cmd.clr_step ? r_clr_ptr : r_tr_ptr;
        mem_wdata = i_cmd.clr_step ? 1'b0 : r_tr_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wave[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_wave[IW'(r_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_level  <= (r_mode == MODE_READ) & r_rd;
            r_out_prefix <= r_prefix;
            r_out_pend   <= r_pend_valid;
        end
    end

    always_comb begin
        low_half = r_pend_slot < ADC_W'(BUF_LEN / 2);
        fits     = r_free_half ? !low_half : low_half;
        o_stat.clr_last   = (r_clr_ptr == IW'(BUF_LEN - 1));
        o_stat.div_busy   = (r_dv_cnt != '0);
        o_stat.erase_go   = r_erase_valid && (r_clear_delay == CLR_DELAY_MAX);
        o_stat.fill_go    = r_pend_valid && (r_prefix == r_pend_prefix) && fits;
        o_stat.train_done = (r_tr_k == r_pulse_count);
        o_stat.mode       = r_mode;
    end

    assign o_pin_level      = r_out_level;
    assign o_current_prefix = r_out_prefix;
    assign o_ping_pending   = r_out_pend;

`include "assert_macros.svh"
    `PPS_ASSERT_IMP(a_div_idle_start, i_cmd.div_start, r_dv_cnt == '0)
    `PPS_ASSERT_IMP(a_train_ptr_range, i_cmd.train_step, r_tr_ptr <= IW'(BUF_LEN - 1))
    `PPS_ASSERT_NXT(a_fill_arms_erase, i_cmd.train_fill, r_erase_valid && !r_pend_valid)

endmodule
`default_nettype wire

@@ hdl/pps_ctrl.sv @@
`default_nettype none
module pps_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire pps_pkg::t_stat i_stat,
    output pps_pkg::t_cmd       o_cmd
);
    import pps_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DISP  = 11'b00000000100,
        S_DVA   = 11'b00000001000,
        S_PER   = 11'b00000010000,
        S_DVP   = 11'b00000100000,
        S_ECHK  = 11'b00001000000,
        S_ERASE = 11'b00010000000,
        S_FCHK  = 11'b00100000000,
        S_FILL  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.mode)
                    MODE_SCHED: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_ADC;
                        n_state         = S_DVA;
                    end
                    MODE_UPDATE: begin
                        o_cmd.upd_periodic = 1'b1;
                        n_state            = S_ECHK;
                    end
                    MODE_HALF1: begin
                        o_cmd.half1 = 1'b1;
                        n_state     = S_PER;
                    end
                    MODE_HALF2: begin
                        o_cmd.half2 = 1'b1;
                        n_state     = S_DONE;
                    end
                    MODE_READ: begin
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DVA: begin
                if (!i_stat.div_busy) begin
                    o_cmd.sched_commit = 1'b1;
                    n_state            = S_DONE;
                end
            end
            S_PER: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PFX;
                n_state         = S_DVP;
            end
            S_DVP: begin
                if (!i_stat.div_busy) begin
                    o_cmd.period_apply = 1'b1;
                    n_state            = S_DONE;
                end
            end
            S_ECHK: begin
                if (i_stat.erase_go) begin
                    o_cmd.train_erase = 1'b1;
                    n_state           = S_ERASE;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_ERASE: begin
                if (i_stat.train_done) begin
                    n_state = S_FCHK;
                end else begin
                    o_cmd.train_step = 1'b1;
                end
            end
            S_FCHK: begin
                if (i_stat.fill_go) begin
                    o_cmd.train_fill = 1'b1;
                    n_state          = S_FILL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                if (i_stat.train_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.train_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`include "assert_macros.svh"
    `PPS_ASSERT_NXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready)
    `PPS_ASSERT_IMP(a_load_when_free, o_cmd.out_load, !r_out_valid || i_out_ready)
    `PPS_ASSERT_NXT(a_load_shows, o_cmd.out_load, o_out_valid && o_in_ready)

endmodule
`default_nettype wire

@@ bench/pps_beat_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pps_beat_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pps_pkg::CFG_W-1:0]     i_cfg_data,
    pps_in_if                                  i_in_bus,
    pps_out_if                                 i_out_bus,
    output int                                 o_fail_count,
    output int                                 o_waiting
);
    import pps_pkg::*;

    localparam int SLOTS = BUF_LEN_DEF;

    typedef struct packed {
        logic             pin_level;
        logic [PFX_W-1:0] current_prefix;
        logic             ping_pending;
    } t_report;

    logic [CNT_W-1:0] train_len;
    logic [SPS_W-1:0] slot_div;
    logic [PFX_W-1:0] period_len;
    logic             auto_ping;

    logic             free_half;
    logic [PFX_W-1:0] prefix_cnt;
    logic [1:0]       clr_wait;
    logic             period_hit;
    logic             ping_armed;
    logic [15:0]      ping_slot;
    logic [PFX_W-1:0] ping_prefix;
    logic             erase_armed;
    logic [15:0]      erase_at;
    bit               wave [SLOTS];

    t_report          report_q [$];

    function automatic void clear_schedule();
        train_len   = PULSE_COUNT_RST;
        slot_div    = SPS_RST;
        period_len  = '0;
        auto_ping   = 1'b0;
        free_half   = 1'b1;
        prefix_cnt  = '0;
        clr_wait    = CLR_DELAY_MAX;
        period_hit  = 1'b0;
        ping_armed  = 1'b0;
        ping_slot   = '0;
        ping_prefix = '0;
        erase_armed = 1'b0;
        erase_at    = '0;
        for (int s = 0; s < SLOTS; s++) wave[s] = 1'b0;
    endfunction

    function automatic void paint_train(input logic [15:0] start, input bit level);
        for (int k = 0; k < int'(train_len); k++) wave[(int'(start) + 2 * k) % SLOTS] = level;
    endfunction

    function automatic void age_clear();
        if (clr_wait < CLR_DELAY_MAX) clr_wait = clr_wait + 2'd1;
    endfunction

    function automatic void refresh_wave();
        bit low_half;
        bit fits;
        if (auto_ping && period_hit) begin
            ping_slot   = '0;
            ping_prefix = prefix_cnt;
            ping_armed  = 1'b1;
            period_hit  = 1'b0;
        end
        if (erase_armed && clr_wait == CLR_DELAY_MAX) begin
            paint_train(erase_at, 1'b0);
            erase_armed = 1'b0;
        end
        if (ping_armed && prefix_cnt == ping_prefix) begin
            low_half = (int'(ping_slot) < SLOTS / 2);
            fits     = (free_half == 1'b0) ? low_half : !low_half;
            if (fits) begin
                paint_train(ping_slot, 1'b1);
                erase_at    = ping_slot;
                erase_armed = 1'b1;
                clr_wait    = '0;
                ping_armed  = 1'b0;
            end
        end
    endfunction

    function automatic t_report step_pulses(input logic [MODE_W-1:0] mode,
                                            input logic [ADC_W-1:0]  adc,
                                            input logic [PFX_W-1:0]  pfx,
                                            input logic [ADDR_W-1:0] addr);
        t_report rep;
        int      div;
        rep.pin_level = 1'b0;
        case (mode)
            MODE_SCHED: begin
                div         = (slot_div == '0) ? 1 : int'(slot_div);
                ping_slot   = 16'(int'(adc) / div);
                ping_prefix = pfx;
                ping_armed  = 1'b1;
            end
            MODE_UPDATE: refresh_wave();
            MODE_HALF1: begin
                prefix_cnt = prefix_cnt + 1'b1;
                free_half  = 1'b0;
                age_clear();
                if (period_len != '0 && (prefix_cnt % period_len) == '0) period_hit = 1'b1;
            end
            MODE_HALF2: begin
                free_half = 1'b1;
                age_clear();
            end
            MODE_READ: rep.pin_level = wave[int'(addr) % SLOTS];
            default: ;
        endcase
        rep.current_prefix = prefix_cnt;
        rep.ping_pending   = ping_armed;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            clear_schedule();
            report_q.delete();
        end else begin
            if (i_out_bus.valid && i_out_bus.ready) begin
                if (report_q.size() == 0) begin
                    $error("result beat with no report expected");
                    o_fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (i_out_bus.pin_level !== want.pin_level) begin
                        $error("pin_level: expected %0d, actual %0d",
                               want.pin_level, i_out_bus.pin_level);
                        o_fail_count++;
                    end
                    if (i_out_bus.current_prefix !== want.current_prefix) begin
                        $error("current_prefix: expected %0d, actual %0d",
                               want.current_prefix, i_out_bus.current_prefix);
                        o_fail_count++;
                    end
                    if (i_out_bus.ping_pending !== want.ping_pending) begin
                        $error("ping_pending: expected %0d, actual %0d",
                               want.ping_pending, i_out_bus.ping_pending);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PULSE_COUNT: train_len  = i_cfg_data[CNT_W-1:0];
                    CFG_SPS:         slot_div   = i_cfg_data[SPS_W-1:0];
                    CFG_PERIOD:      period_len = i_cfg_data[PFX_W-1:0];
                    CFG_PERIODIC_ON: auto_ping  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_bus.valid && i_in_bus.ready) begin
                report_q.push_back(step_pulses(i_in_bus.mode, i_in_bus.adc_index,
                                               i_in_bus.target_prefix, i_in_bus.slot_address));
            end
        end
        o_waiting = report_q.size();
    end
endmodule
`default_nettype wire

@@ bench/ping_pulse_scheduler_top_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ping_pulse_scheduler_top_test;
    import pps_pkg::*;

    localparam int RUN_LIMIT    = 3000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 600;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    pps_in_if  in_bus ();
    pps_out_if out_bus ();

    int               fail_count;
    int               waiting;
    int               send_idle_pct;
    int               sink_stall_pct;
    int               hold_asked;
    int               hold_served;
    int               hold_left;
    int               cycle_count;
    int               items_left;
    logic [PFX_W-1:0] prefix_seen;
    logic [CNT_W-1:0] train_len;
    logic [SPS_W-1:0] slot_div;
    bit               low_next;

    ping_pulse_scheduler_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    pps_beat_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_bus     (in_bus),
        .i_out_bus    (out_bus),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL ping_pulse_scheduler_top");
        $finish;
    end

    initial begin
        out_bus.ready = 1'b0;
        hold_served   = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ADC_W-1:0] adc,
                             input logic [PFX_W-1:0] pfx, input logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.mode          <= mode;
        in_bus.adc_index     <= adc;
        in_bus.target_prefix <= pfx;
        in_bus.slot_address  <= addr;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        if (mode == MODE_HALF1) prefix_seen = prefix_seen + 1'b1;
        items_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
    endtask

    // advance one half, then try to land a ping in the half just freed
    task automatic play_half(input bit low);
        int               div;
        int               slot;
        int               adc;
        int               reps;
        logic [PFX_W-1:0] tgt;
        logic [ADDR_W-1:0] addr;
        div = (slot_div == '0) ? 1 : int'(slot_div);
        send_item(low ? MODE_HALF1 : MODE_HALF2, ADC_W'($urandom), PFX_W'($urandom),
                  ADDR_W'($urandom));
        slot = low ? $urandom_range(0, 127) : $urandom_range(128, 255);
        if ($urandom_range(0, 7) == 0) slot = $urandom_range(0, 65535 / div);
        adc = slot * div + $urandom_range(0, div - 1);
        if (adc > 65535) adc = 65535;
        tgt = prefix_seen;
        case ($urandom_range(0, 7))
            0: tgt = prefix_seen + 1'b1;
            1: tgt = PFX_W'($urandom);
            default: ;
        endcase
        if ($urandom_range(0, 4) != 0)
            send_item(MODE_SCHED, adc[ADC_W-1:0], tgt, ADDR_W'($urandom));
        reps = $urandom_range(1, 2);
        repeat (reps)
            send_item(MODE_UPDATE, ADC_W'($urandom), PFX_W'($urandom), ADDR_W'($urandom));
        reps = $urandom_range(1, 4);
        repeat (reps) begin
            if ($urandom_range(0, 3) == 0) addr = ADDR_W'($urandom);
            else addr = ADDR_W'(slot + $urandom_range(0, 2 * int'(train_len)));
            send_item(MODE_READ, ADC_W'($urandom), PFX_W'($urandom), addr);
        end
    endtask

    task automatic run_phase(input int pulses, input int divisor, input int period,
                             input int enable, input int idle_pct, input int stall_pct,
                             input int count, input bit squeeze);
        settle();
        write_reg(CFG_PULSE_COUNT, pulses);
        write_reg(CFG_SPS, divisor);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_PERIODIC_ON, enable);
        train_len      = pulses[CNT_W-1:0];
        slot_div       = divisor[SPS_W-1:0];
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        if (squeeze) hold_asked++;
        items_left = count;
        while (items_left > 0) begin
            if ($urandom_range(0, 3) != 0) begin
                play_half(low_next);
                low_next = !low_next;
            end else begin
                send_item(MODE_W'($urandom_range(0, (1 << MODE_W) - 1)), ADC_W'($urandom),
                          PFX_W'($urandom), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        in_bus.valid         = 1'b0;
        in_bus.mode          = MODE_SCHED;
        in_bus.adc_index     = '0;
        in_bus.target_prefix = '0;
        in_bus.slot_address  = '0;
        send_idle_pct        = 0;
        sink_stall_pct       = 0;
        hold_asked           = 0;
        items_left           = 0;
        prefix_seen          = '0;
        train_len            = PULSE_COUNT_RST;
        slot_div             = SPS_RST;
        low_next             = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(MODE_READ, '0, '0, '0);
        send_item(MODE_READ, '1, '1, '1);
        for (int m = int'(MODE_READ) + 1; m < (1 << MODE_W); m++)
            send_item(MODE_W'(m), ADC_W'($urandom), PFX_W'($urandom), ADDR_W'($urandom));
        send_item(MODE_SCHED, '1, '1, '0);
        send_item(MODE_SCHED, 16'd6, 15'd0, '0);
        send_item(MODE_UPDATE, '0, '0, '0);
        send_item(MODE_HALF1, '0, '0, '0);
        send_item(MODE_SCHED, 16'd12, 15'd1, '0);
        send_item(MODE_UPDATE, '0, '0, '0);
        send_item(MODE_READ, '0, '0, 8'd2);
        send_item(MODE_READ, '0, '0, 8'd3);
        send_item(MODE_READ, '0, '0, 8'd8);
        send_item(MODE_READ, '0, '0, 8'd10);
        send_item(MODE_HALF2, '0, '0, '0);
        send_item(MODE_SCHED, 16'd1200, 15'd1, '0);
        send_item(MODE_UPDATE, '0, '0, '0);
        send_item(MODE_HALF1, '0, '0, '0);
        send_item(MODE_HALF2, '0, '0, '0);
        send_item(MODE_UPDATE, '0, '0, '0);
        send_item(MODE_READ, '0, '0, 8'd200);
        send_item(MODE_READ, '0, '0, 8'd2);
        send_item(MODE_READ, '0, '0, 8'd206);

        run_phase(1, 1, 1, 1, 0, 0, 140, 1'b1);
        run_phase(0, 0, 3, 0, 83, 0, 140, 1'b0);
        run_phase(128, 255, 32767, 1, 0, 83, 140, 1'b0);
        run_phase(7, 6, 5, 1, 13, 13, 140, 1'b0);
        run_phase(3, 100, 0, 1, 0, 0, 140, 1'b0);
        run_phase(16, 2, 2, 0, 83, 0, 140, 1'b0);
        run_phase(5, 13, 4, 1, 0, 83, 140, 1'b0);
        run_phase(2, 1, 7, 1, 13, 13, 140, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("PASS ping_pulse_scheduler_top");
        end else begin
            $display("FAIL ping_pulse_scheduler_top");
        end
        $finish;
    end
endmodule
`default_nettype wire
